@@ src/pscg_pkg.sv @@
// Package for the PC-sample call-graph counter: sizes, codes, the
// controller/datapath command and status structs, and a saturating add.
// No dependencies.
`timescale 1ns / 1ps
package pscg_pkg;
  localparam int NUM_FUNCS = 1024;
  localparam int FUNC_W = 10;
  localparam int EDGE_SLOTS = 32;
  localparam int SLOT_W = 5;
  localparam int USED_W = 6;
  localparam int CNT_W = 32;
  localparam int ADDR_W = 64;
  localparam int ACT_W = 11;
  localparam int EADDR_W = FUNC_W + SLOT_W;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_RD_CNT = 2'd2;
  localparam logic [1:0] OP_RD_EDGE = 2'd3;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_CG_EN = 1'b1;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic load_wr;
    logic srch_run;
    logic rd_m;
    logic rd_ce;
    logic rd_out;
    logic self_wr;
    logic scan_init0;
    logic scan_init1;
    logic scan_rd;
    logic scan_cmp;
    logic scan_wr;
    logic res_cap;
  } pscg_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic srch_done;
    logic srch_hit;
    logic edge_go;
    logic cer_room;
    logic scan_more;
    logic scan_match;
    logic scan_dir;
  } pscg_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction
endpackage

@@ src/pscg_ctrl.sv @@
// Sequencer for the call-graph counter: clear pass, table load, search,
// count update, edge list scans and result hand-off. Uses pscg_pkg.
`timescale 1ns / 1ps
module pscg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          opcode,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pscg_pkg::pscg_sts_t sts,
  output pscg_pkg::pscg_cmd_t cmd
);
  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LOAD     = 14'b00000000000100,
    S_SRCH     = 14'b00000000001000,
    S_CNT_RD   = 14'b00000000010000,
    S_CNT_WAIT = 14'b00000000100000,
    S_SC_RD    = 14'b00000001000000,
    S_SC_CMP   = 14'b00000010000000,
    S_SC_WR    = 14'b00000100000000,
    S_USED_RD  = 14'b00001000000000,
    S_USED_WT  = 14'b00010000000000,
    S_OUT_RD   = 14'b00100000000000,
    S_OUT_WAIT = 14'b01000000000000,
    S_HOLD     = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_HOLD);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (opcode)
            pscg_pkg::OP_LOAD:   state_next = S_LOAD;
            pscg_pkg::OP_SAMPLE: state_next = S_SRCH;
            default:             state_next = S_OUT_RD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next = S_OUT_RD;
      end
      S_SRCH: begin
        cmd.srch_run = 1'b1;
        if (sts.srch_done) state_next = sts.srch_hit ? S_CNT_RD : S_OUT_RD;
      end
      S_CNT_RD: begin
        cmd.rd_m = 1'b1;
        state_next = S_CNT_WAIT;
      end
      S_CNT_WAIT: begin
        cmd.self_wr = 1'b1;
        if (sts.edge_go) begin
          cmd.scan_init0 = 1'b1;
          state_next = S_SC_RD;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_SC_RD: begin
        if (sts.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_next = S_SC_CMP;
        end else begin
          state_next = S_SC_WR;
        end
      end
      S_SC_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next = sts.scan_match ? S_SC_WR : S_SC_RD;
      end
      S_SC_WR: begin
        cmd.scan_wr = 1'b1;
        state_next = sts.scan_dir ? S_OUT_RD : S_USED_RD;
      end
      S_USED_RD: begin
        cmd.rd_ce = 1'b1;
        state_next = S_USED_WT;
      end
      S_USED_WT: begin
        if (sts.cer_room) begin
          cmd.scan_init1 = 1'b1;
          state_next = S_SC_RD;
        end else begin
          state_next = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        cmd.res_cap = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

@@ src/pscg_dp.sv @@
// Datapath of the call-graph counter: range, counter and edge memories,
// search pipeline, list scanner and result registers. Uses pscg_pkg.
`timescale 1ns / 1ps
module pscg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pscg_pkg::ACT_W-1:0]        cfg_data,
  input  logic [1:0]                        opcode,
  input  logic [pscg_pkg::FUNC_W-1:0]       entry_index,
  input  logic [pscg_pkg::ADDR_W-1:0]       range_start_in,
  input  logic [pscg_pkg::ADDR_W-1:0]       range_end_in,
  input  logic [pscg_pkg::ADDR_W-1:0]       frame_addr,
  input  logic                              first_frame,
  input  logic                              last_frame,
  input  logic                              edge_dir,
  input  logic [pscg_pkg::SLOT_W-1:0]       edge_slot,
  input  pscg_pkg::pscg_cmd_t               cmd,
  output pscg_pkg::pscg_sts_t               sts,
  output logic                              match_found,
  output logic [pscg_pkg::FUNC_W-1:0]       match_index,
  output logic [pscg_pkg::CNT_W-1:0]        self_samples,
  output logic [pscg_pkg::CNT_W-1:0]        total_samples,
  output logic [pscg_pkg::USED_W-1:0]       callee_entries,
  output logic [pscg_pkg::USED_W-1:0]       caller_entries,
  output logic                              edge_valid,
  output logic [pscg_pkg::FUNC_W-1:0]       edge_partner,
  output logic [pscg_pkg::CNT_W-1:0]        edge_hits
);
  localparam int FW = pscg_pkg::FUNC_W;
  localparam int CW = pscg_pkg::CNT_W;
  localparam int UW = pscg_pkg::USED_W;
  localparam int AW = pscg_pkg::ADDR_W;
  localparam int EW = pscg_pkg::EADDR_W;
  localparam int SW = pscg_pkg::SLOT_W;
  localparam logic [UW-1:0] SLOTS = UW'(pscg_pkg::EDGE_SLOTS);
  localparam logic [pscg_pkg::ACT_W-1:0] NF = pscg_pkg::ACT_W'(pscg_pkg::NUM_FUNCS);

  // configuration
  logic [pscg_pkg::ACT_W-1:0] active;
  logic cg_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      cg_en <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == pscg_pkg::CFG_ACTIVE) active <= cfg_data;
      else cg_en <= cfg_data[0];
    end
  end

  // captured transaction
  logic [1:0] op_q;
  logic [FW-1:0] e_q;
  logic [AW-1:0] start_q, end_q, frame_q;
  logic first_q, last_q, dir_q;
  logic [SW-1:0] s_q;
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q <= opcode;
      e_q <= entry_index;
      start_q <= range_start_in;
      end_q <= range_end_in;
      frame_q <= frame_addr;
      first_q <= first_frame;
      last_q <= last_frame;
      dir_q <= edge_dir;
      s_q <= edge_slot;
    end
  end

  // clear pass over the counter memories
  logic [FW-1:0] clr_idx;
  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clr_wr) clr_idx <= clr_idx + 1'b1;
  end

  // range memories and search
  logic [AW-1:0] lo_mem [pscg_pkg::NUM_FUNCS];
  logic [AW-1:0] hi_mem [pscg_pkg::NUM_FUNCS];
  logic [AW-1:0] lo_rd, hi_rd;
  logic [pscg_pkg::ACT_W-1:0] issue, n_act;
  logic pend, match_now, hit;
  logic [FW-1:0] pend_idx, m, ce, prev_func;
  logic ce_ok, prev_hit;

  assign n_act = (active > NF) ? NF : active;
  assign match_now = pend && (frame_q >= lo_rd) && (frame_q < hi_rd);

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      lo_mem[e_q] <= start_q;
      hi_mem[e_q] <= end_q;
    end
    lo_rd <= lo_mem[issue[FW-1:0]];
    hi_rd <= hi_mem[issue[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      prev_func <= '0;
      prev_hit <= 1'b0;
    end else if (cmd.take) begin
      issue <= '0;
      pend <= 1'b0;
      hit <= 1'b0;
      m <= '0;
      ce <= prev_func;
      ce_ok <= prev_hit;
    end else if (cmd.srch_run) begin
      pend <= (issue < n_act);
      pend_idx <= issue[FW-1:0];
      if (issue < n_act) issue <= issue + 1'b1;
      hit <= match_now;
      if (match_now) m <= pend_idx;
      if (sts.srch_done) begin
        prev_func <= match_now ? pend_idx : '0;
        prev_hit <= match_now && !last_q;
      end
    end
  end

  // counter memories
  logic [CW-1:0] self_mem [pscg_pkg::NUM_FUNCS];
  logic [CW-1:0] total_mem [pscg_pkg::NUM_FUNCS];
  logic [UW-1:0] ceu_mem [pscg_pkg::NUM_FUNCS];
  logic [UW-1:0] cru_mem [pscg_pkg::NUM_FUNCS];
  logic [CW-1:0] self_rd, total_rd, self_wd, total_wd;
  logic [UW-1:0] ceu_rd, cru_rd, used_wd;
  logic [FW-1:0] c_raddr, c_waddr;
  logic self_we, total_we, ceu_we, cru_we;

  // scanner
  logic sdir, found;
  logic [FW-1:0] owner, partner;
  logic [UW-1:0] scnt, j;
  logic [FW-1:0] cee_who_rd, cer_who_rd;
  logic [CW-1:0] cee_hits_rd, cer_hits_rd;

  always_comb begin
    c_raddr = e_q;
    if (cmd.rd_m) c_raddr = m;
    else if (cmd.rd_ce) c_raddr = ce;
    else if (cmd.rd_out && op_q == pscg_pkg::OP_SAMPLE) c_raddr = m;
  end

  always_comb begin
    c_waddr = e_q;
    self_we = 1'b0;
    total_we = 1'b0;
    ceu_we = 1'b0;
    cru_we = 1'b0;
    self_wd = '0;
    total_wd = '0;
    used_wd = '0;
    if (cmd.clr_wr || cmd.load_wr) begin
      c_waddr = cmd.clr_wr ? clr_idx : e_q;
      self_we = 1'b1;
      total_we = 1'b1;
      ceu_we = 1'b1;
      cru_we = 1'b1;
    end else if (cmd.self_wr) begin
      c_waddr = m;
      self_we = 1'b1;
      total_we = 1'b1;
      self_wd = first_q ? pscg_pkg::sat_inc(self_rd) : self_rd;
      total_wd = cg_en ? pscg_pkg::sat_inc(total_rd) : total_rd;
    end else if (cmd.scan_wr && !found) begin
      c_waddr = owner;
      used_wd = scnt + 1'b1;
      ceu_we = !sdir;
      cru_we = sdir;
    end
  end

  always_ff @(posedge clk) begin
    if (self_we) self_mem[c_waddr] <= self_wd;
    if (total_we) total_mem[c_waddr] <= total_wd;
    if (ceu_we) ceu_mem[c_waddr] <= used_wd;
    if (cru_we) cru_mem[c_waddr] <= used_wd;
    self_rd <= self_mem[c_raddr];
    total_rd <= total_mem[c_raddr];
    ceu_rd <= ceu_mem[c_raddr];
    cru_rd <= cru_mem[c_raddr];
  end

  // edge memories
  logic [FW-1:0] cee_who_mem [pscg_pkg::NUM_FUNCS * pscg_pkg::EDGE_SLOTS];
  logic [CW-1:0] cee_hits_mem [pscg_pkg::NUM_FUNCS * pscg_pkg::EDGE_SLOTS];
  logic [FW-1:0] cer_who_mem [pscg_pkg::NUM_FUNCS * pscg_pkg::EDGE_SLOTS];
  logic [CW-1:0] cer_hits_mem [pscg_pkg::NUM_FUNCS * pscg_pkg::EDGE_SLOTS];
  logic [EW-1:0] e_raddr, e_waddr;
  logic [CW-1:0] hits_wd, hits_sel;
  logic who_we, hits_we;

  // keep the scanned slot on the read port through the compare cycle so the
  // hit count of a matching slot is still there for the write
  assign e_raddr = (cmd.scan_rd || cmd.scan_cmp) ? {owner, j[SW-1:0]} : {e_q, s_q};
  assign hits_sel = sdir ? cer_hits_rd : cee_hits_rd;
  assign who_we = cmd.scan_wr && !found;
  assign hits_we = cmd.scan_wr;
  assign e_waddr = found ? {owner, j[SW-1:0]} : {owner, scnt[SW-1:0]};
  assign hits_wd = found ? pscg_pkg::sat_inc(hits_sel) : CW'(1);

  always_ff @(posedge clk) begin
    if (who_we && !sdir) cee_who_mem[e_waddr] <= partner;
    if (hits_we && !sdir) cee_hits_mem[e_waddr] <= hits_wd;
    if (who_we && sdir) cer_who_mem[e_waddr] <= partner;
    if (hits_we && sdir) cer_hits_mem[e_waddr] <= hits_wd;
    cee_who_rd <= cee_who_mem[e_raddr];
    cee_hits_rd <= cee_hits_mem[e_raddr];
    cer_who_rd <= cer_who_mem[e_raddr];
    cer_hits_rd <= cer_hits_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init0) begin
      sdir <= 1'b0;
      owner <= m;
      partner <= ce;
      scnt <= ceu_rd;
      j <= '0;
      found <= 1'b0;
    end else if (cmd.scan_init1) begin
      sdir <= 1'b1;
      owner <= ce;
      partner <= m;
      scnt <= cru_rd;
      j <= '0;
      found <= 1'b0;
    end else if (cmd.scan_cmp) begin
      if (sts.scan_match) found <= 1'b1;
      else j <= j + 1'b1;
    end
  end

  always_comb begin
    sts.clr_done = (clr_idx == {FW{1'b1}});
    sts.srch_done = match_now || (!pend && issue >= n_act);
    sts.srch_hit = match_now;
    sts.edge_go = cg_en && !first_q && ce_ok && (ceu_rd < SLOTS);
    sts.cer_room = (cru_rd < SLOTS);
    sts.scan_more = (j < scnt);
    sts.scan_match = ((sdir ? cer_who_rd : cee_who_rd) == partner);
    sts.scan_dir = sdir;
  end

  // results
  logic [UW-1:0] rd_cnt;
  logic show_cnt;
  assign rd_cnt = dir_q ? cru_rd : ceu_rd;
  assign show_cnt = (op_q == pscg_pkg::OP_SAMPLE) ? hit : (op_q != pscg_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (cmd.res_cap) begin
      match_found <= (op_q == pscg_pkg::OP_SAMPLE) && hit;
      match_index <= (op_q == pscg_pkg::OP_SAMPLE) ? m : '0;
      self_samples <= show_cnt ? self_rd : '0;
      total_samples <= show_cnt ? total_rd : '0;
      callee_entries <= show_cnt ? ceu_rd : '0;
      caller_entries <= show_cnt ? cru_rd : '0;
      if (op_q == pscg_pkg::OP_RD_EDGE && {1'b0, s_q} < rd_cnt) begin
        edge_valid <= 1'b1;
        edge_partner <= dir_q ? cer_who_rd : cee_who_rd;
        edge_hits <= dir_q ? cer_hits_rd : cee_hits_rd;
      end else begin
        edge_valid <= 1'b0;
        edge_partner <= '0;
        edge_hits <= '0;
      end
    end
  end
endmodule

@@ src/pc_sample_call_graph_counter.sv @@
// Top level of the PC-sample call-graph counter: controller plus datapath.
// Depends on pscg_pkg, pscg_ctrl and pscg_dp.
//
// One transaction at a time. After reset a clearing pass zeroes the
// per-function counters; no input is taken during it (config writes are).
// A load is opcode 0 and a read is opcode 2 or 3.
// A frame (opcode 1) runs a linear range search that reads one table entry per
// cycle and stops at the first match or after the clamped active_functions
// entries. A matched frame with call graph enabled that is not the first of
// its stack and follows a matched frame then scans the caller's callee list
// and then the callee's caller list, each scan only if that list has room.
// The single read port of the range memories sets the search rate. A result
// is held until taken.
`timescale 1ns / 1ps
module pc_sample_call_graph_counter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [pscg_pkg::ACT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [pscg_pkg::FUNC_W-1:0]       entry_index,
  input  logic [pscg_pkg::ADDR_W-1:0]       range_start_in,
  input  logic [pscg_pkg::ADDR_W-1:0]       range_end_in,
  input  logic [pscg_pkg::ADDR_W-1:0]       frame_addr,
  input  logic                              first_frame,
  input  logic                              last_frame,
  input  logic                              edge_dir,
  input  logic [pscg_pkg::SLOT_W-1:0]       edge_slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              match_found,
  output logic [pscg_pkg::FUNC_W-1:0]       match_index,
  output logic [pscg_pkg::CNT_W-1:0]        self_samples,
  output logic [pscg_pkg::CNT_W-1:0]        total_samples,
  output logic [pscg_pkg::USED_W-1:0]       callee_entries,
  output logic [pscg_pkg::USED_W-1:0]       caller_entries,
  output logic                              edge_valid,
  output logic [pscg_pkg::FUNC_W-1:0]       edge_partner,
  output logic [pscg_pkg::CNT_W-1:0]        edge_hits
);
  pscg_pkg::pscg_cmd_t cmd;
  pscg_pkg::pscg_sts_t sts;

  // config registers are plain flops, always writable
  assign cfg_ready = 1'b1;

  pscg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pscg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .range_start_in (range_start_in),
    .range_end_in   (range_end_in),
    .frame_addr     (frame_addr),
    .first_frame    (first_frame),
    .last_frame     (last_frame),
    .edge_dir       (edge_dir),
    .edge_slot      (edge_slot),
    .cmd            (cmd),
    .sts            (sts),
    .match_found    (match_found),
    .match_index    (match_index),
    .self_samples   (self_samples),
    .total_samples  (total_samples),
    .callee_entries (callee_entries),
    .caller_entries (caller_entries),
    .edge_valid     (edge_valid),
    .edge_partner   (edge_partner),
    .edge_hits      (edge_hits)
  );
endmodule
